FILE: sv/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_PAIRS_DEF   = 4096;

	// Width of the sample and result fields on the ports.
	localparam int FIELD_W = 16;
	localparam int COUNT_W = 13;
	localparam int STATUS_W = 2;

	// Q2.14: one is 2^14, and the search runs over 0..Q_ONE.
	localparam int Q_ONE   = 16384;
	localparam int Q_W     = 15;
	// Numerator scale of the rounding search is 2 * Q_ONE = 2^15.
	localparam int A_SHIFT = 15;

	// Depth of the queue of finished sets between front and back.
	localparam int QUEUE_DEPTH = 4;

	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FLAT = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_OVF  = 2'd3;

	typedef struct packed {
		logic signed [FIELD_W-1:0] x_sample;
		logic signed [FIELD_W-1:0] y_sample;
		logic                      last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] coefficient;
		logic [COUNT_W-1:0]        pair_count;
		logic [STATUS_W-1:0]       status;
	} out_item_t;

endpackage

`default_nettype wire

FILE: sv/pcc_queue.sv
`default_nettype none

module pcc_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [W-1:0]                 din,
	input  wire logic                         pop,
	output logic      [W-1:0]                 dout,
	output logic      [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign do_pop = pop && (count_q != '0);
	assign dout   = mem_q[rd_ptr_q];
	assign count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= CW'(count_q + 1'b1);
				2'b01:   count_q <= CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

FILE: sv/pcc_front.sv
`default_nettype none

module pcc_front import pcc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_PAIRS   = MAX_PAIRS_DEF,
	parameter int NB          = $clog2(MAX_PAIRS+1),
	parameter int SW          = SAMPLE_BITS + NB,
	parameter int QW          = 2*SAMPLE_BITS + NB,
	parameter int SNAP_W      = 1 + NB + 2*SW + 3*QW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire in_item_t          sample,
	output logic                   snap_push,
	output logic [SNAP_W-1:0]      snap,
	output logic [1:0]             lasts_pending
);

	localparam int SB = SAMPLE_BITS;

	logic                   v_s1, last_s1;
	logic signed [SB-1:0]   x_s1, y_s1;
	logic                   v_s2, last_s2;
	logic signed [SB-1:0]   x_s2, y_s2;
	logic signed [2*SB-1:0] xx_s2, yy_s2, xy_s2;

	logic [NB-1:0]          n_q, n_nx;
	logic signed [SW-1:0]   sx_q, sy_q, sx_nx, sy_nx;
	logic signed [QW-1:0]   sxx_q, syy_q, sxy_q, sxx_nx, syy_nx, sxy_nx;
	logic                   ovf_q, ovf_nx;
	logic                   at_max, add_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= in_valid;
			last_s1 <= in_valid && sample.last_sample;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= SB'(sample.x_sample);
		y_s1  <= SB'(sample.y_sample);
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		xx_s2 <= x_s1 * x_s1;
		yy_s2 <= y_s1 * y_s1;
		xy_s2 <= x_s1 * y_s1;
	end

	// Once the set is full, further pairs only mark the overflow.
	assign at_max = (n_q == NB'(MAX_PAIRS));
	assign add_en = v_s2 && !at_max;

	always_comb begin
		n_nx   = add_en ? NB'(n_q + 1'b1) : n_q;
		sx_nx  = add_en ? SW'(sx_q + SW'(x_s2)) : sx_q;
		sy_nx  = add_en ? SW'(sy_q + SW'(y_s2)) : sy_q;
		sxx_nx = add_en ? QW'(sxx_q + QW'(xx_s2)) : sxx_q;
		syy_nx = add_en ? QW'(syy_q + QW'(yy_s2)) : syy_q;
		sxy_nx = add_en ? QW'(sxy_q + QW'(xy_s2)) : sxy_q;
		ovf_nx = ovf_q || (v_s2 && at_max);
	end

	assign snap_push     = v_s2 && last_s2;
	assign snap          = {ovf_nx, n_nx, sx_nx, sy_nx, sxx_nx, syy_nx, sxy_nx};
	assign lasts_pending = 2'(last_s1) + 2'(last_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
			ovf_q <= 1'b0;
		end else if (v_s2) begin
			if (last_s2) begin
				n_q   <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
				sxx_q <= '0;
				syy_q <= '0;
				sxy_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				n_q   <= n_nx;
				sx_q  <= sx_nx;
				sy_q  <= sy_nx;
				sxx_q <= sxx_nx;
				syy_q <= syy_nx;
				sxy_q <= sxy_nx;
				ovf_q <= ovf_nx;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/pcc_mul.sv
`default_nettype none

module pcc_mul #(
	parameter int BW = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [BW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output logic                      done,
	output logic signed [BW-1:0]      result
);

	logic          busy_q, done_q, neg_q;
	logic [BW-1:0] a_q, b_q, acc_q, result_q;

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift-add on magnitudes, one multiplier bit per cycle, sign at the end.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a[BW-1] ? BW'(-a) : BW'(a);
			b_q   <= b[BW-1] ? BW'(-b) : BW'(b);
			neg_q <= a[BW-1] ^ b[BW-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q == '0) begin
				result_q <= neg_q ? BW'(-acc_q) : acc_q;
			end else begin
				if (b_q[0]) begin
					acc_q <= BW'(acc_q + a_q);
				end
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/pcc_back.sv
`default_nettype none

module pcc_back import pcc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_PAIRS   = MAX_PAIRS_DEF,
	parameter int NB          = $clog2(MAX_PAIRS+1),
	parameter int SW          = SAMPLE_BITS + NB,
	parameter int QW          = 2*SAMPLE_BITS + NB,
	parameter int SNAP_W      = 1 + NB + 2*SW + 3*QW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              snap_valid,
	input  wire logic [SNAP_W-1:0] snap,
	output logic                   snap_pop,
	output out_item_t              result,
	output logic                   result_valid,
	input  wire logic              result_pop
);

	localparam int MAG = 2*SAMPLE_BITS + 2*NB;
	localparam int BW  = 2*MAG + 31;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_GO    = 7'b0000010,
		S_WAIT  = 7'b0000100,
		S_CHECK = 7'b0001000,
		S_SQ    = 7'b0010000,
		S_OUT   = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	typedef enum logic [3:0] {
		OP_NSXY, OP_SXSY, OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY,
		OP_A2, OP_PROD, OP_LHS
	} op_t;

	logic                 s_ovf;
	logic [NB-1:0]        s_n;
	logic signed [SW-1:0] s_sx, s_sy;
	logic signed [QW-1:0] s_sxx, s_syy, s_sxy;

	state_t               state_q;
	op_t                  op_q;
	logic                 ovf_q, neg_q;
	logic [NB-1:0]        n_q;
	logic signed [SW-1:0] sx_q, sy_q;
	logic signed [QW-1:0] sxx_q, syy_q, sxy_q;
	logic signed [BW-1:0] tmp_q, num_q, dx_q, dy_q, a2_q, prod_q;
	logic [Q_W-1:0]       lo_q, hi_q, mid_q;
	logic [2*Q_W-1:0]     c2_q;
	logic [STATUS_W-1:0]  status_q;
	logic signed [FIELD_W-1:0] coef_q;
	out_item_t            out_q;
	logic                 out_valid_q;

	logic                 mul_start, mul_done;
	logic signed [BW-1:0] mul_a, mul_b, mul_r;
	logic [Q_W:0]         mid_sum;
	logic [Q_W-1:0]       mid_c, c_c;

	assign {s_ovf, s_n, s_sx, s_sy, s_sxx, s_syy, s_sxy} = snap;

	assign snap_pop     = (state_q == S_IDLE) && snap_valid;
	assign mul_start    = (state_q == S_GO);
	assign result       = out_q;
	assign result_valid = out_valid_q;

	always_comb begin
		case (op_q)
			OP_NSXY: begin mul_a = BW'(sxy_q); mul_b = BW'(n_q); end
			OP_SXSY: begin mul_a = BW'(sx_q);  mul_b = BW'(sy_q); end
			OP_NSXX: begin mul_a = BW'(sxx_q); mul_b = BW'(n_q); end
			OP_SXSX: begin mul_a = BW'(sx_q);  mul_b = BW'(sx_q); end
			OP_NSYY: begin mul_a = BW'(syy_q); mul_b = BW'(n_q); end
			OP_SYSY: begin mul_a = BW'(sy_q);  mul_b = BW'(sy_q); end
			OP_A2:   begin mul_a = num_q <<< A_SHIFT; mul_b = num_q <<< A_SHIFT; end
			OP_PROD: begin mul_a = dx_q; mul_b = dy_q; end
			OP_LHS:  begin mul_a = prod_q; mul_b = BW'(c2_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Next probe of the rounding search: mid, then c = 2*mid - 1.
	assign mid_sum = Q_W'(lo_q) + Q_W'(hi_q) + 1'b1 + (Q_W+1)'(0);
	assign mid_c   = mid_sum[Q_W:1];
	assign c_c     = Q_W'({mid_c, 1'b0} - 1'b1);

	pcc_mul #(.BW(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NSXY;
			out_valid_q <= 1'b0;
		end else begin
			if (result_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (snap_valid) begin
						op_q    <= OP_NSXY;
						state_q <= S_GO;
					end
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mul_done) begin
						case (op_q)
							OP_NSXY: begin op_q <= OP_SXSY; state_q <= S_GO; end
							OP_SXSY: begin op_q <= OP_NSXX; state_q <= S_GO; end
							OP_NSXX: begin op_q <= OP_SXSX; state_q <= S_GO; end
							OP_SXSX: begin op_q <= OP_NSYY; state_q <= S_GO; end
							OP_NSYY: begin op_q <= OP_SYSY; state_q <= S_GO; end
							OP_SYSY: state_q <= S_CHECK;
							OP_A2:   begin op_q <= OP_PROD; state_q <= S_GO; end
							default: state_q <= S_SQ;
						endcase
					end
				end
				S_CHECK: begin
					if (ovf_q || (n_q < NB'(2)) || (dx_q == '0) || (dy_q == '0)) begin
						state_q <= S_OUT;
					end else begin
						op_q    <= OP_A2;
						state_q <= S_GO;
					end
				end
				S_SQ: begin
					if (lo_q < hi_q) begin
						op_q    <= OP_LHS;
						state_q <= S_GO;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ovf_q <= s_ovf;
				n_q   <= s_n;
				sx_q  <= s_sx;
				sy_q  <= s_sy;
				sxx_q <= s_sxx;
				syy_q <= s_syy;
				sxy_q <= s_sxy;
			end
			S_WAIT: begin
				if (mul_done) begin
					case (op_q)
						OP_NSXY, OP_NSXX, OP_NSYY: tmp_q <= mul_r;
						OP_SXSY: num_q  <= BW'(tmp_q - mul_r);
						OP_SXSX: dx_q   <= BW'(tmp_q - mul_r);
						OP_SYSY: dy_q   <= BW'(tmp_q - mul_r);
						OP_A2:   a2_q   <= mul_r;
						OP_PROD: begin
							prod_q <= mul_r;
							lo_q   <= '0;
							hi_q   <= Q_W'(Q_ONE);
						end
						OP_LHS: begin
							if (mul_r <= a2_q) begin
								lo_q <= mid_q;
							end else begin
								hi_q <= Q_W'(mid_q - 1'b1);
							end
						end
						default: tmp_q <= tmp_q;
					endcase
				end
			end
			S_CHECK: begin
				coef_q <= '0;
				if (ovf_q) begin
					status_q <= STAT_OVF;
				end else if (n_q < NB'(2)) begin
					status_q <= STAT_FEW;
				end else if ((dx_q == '0) || (dy_q == '0)) begin
					status_q <= STAT_FLAT;
				end else begin
					status_q <= STAT_OK;
				end
				neg_q <= num_q[BW-1];
				num_q <= num_q[BW-1] ? BW'(-num_q) : num_q;
			end
			S_SQ: begin
				mid_q <= mid_c;
				c2_q  <= c_c * c_c;
				if (!(lo_q < hi_q)) begin
					coef_q <= neg_q ? FIELD_W'(-FIELD_W'(lo_q)) : FIELD_W'(lo_q);
				end
			end
			S_OUT: begin
				if (!out_valid_q) begin
					out_q.coefficient <= coef_q;
					out_q.pair_count  <= COUNT_W'(n_q);
					out_q.status      <= status_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/pearson_correlation_top.sv
// Pairs are taken one per cycle while full is low; the running sums stay current with no gap
// between sets. A result for a set comes after its last pair, sooner for small sums and for an
// error status. The shared shift-add multiplier, taking one bit of its second operand per cycle,
// sets the time: six products, the squared numerator, the variance product and a search of up
// to 15 steps. Up to four finished sets wait in a queue meanwhile.
// arst_n clears the sums, the queue and the result slot at once; no clearing pass.
`default_nettype none

module pearson_correlation_top import pcc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_PAIRS   = MAX_PAIRS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	output logic           full,
	input  wire in_item_t  sample,
	output logic           empty,
	input  wire logic      pop,
	output out_item_t      result
);

	// Widths of the count and of the sums follow from the sample width and set size.
	localparam int NB     = $clog2(MAX_PAIRS+1);
	localparam int SW     = SAMPLE_BITS + NB;
	localparam int QW     = 2*SAMPLE_BITS + NB;
	localparam int SNAP_W = 1 + NB + 2*SW + 3*QW;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH+1);
	localparam int FILL_W = CNT_W + 1;

	logic              in_valid;
	logic              snap_push, snap_pop;
	logic [SNAP_W-1:0] snap_in, snap_out;
	logic [CNT_W-1:0]  q_count;
	logic [1:0]        lasts_pending;
	logic [FILL_W-1:0] fill;
	logic              result_valid;

	// An item is taken when push is high and full is low.
	assign in_valid = push && !full;

	// The front holds at most two items in its pipeline, and each could close a set.
	// Counting those with the queue keeps one slot for the item accepted now.
	assign fill = FILL_W'(q_count) + FILL_W'(lasts_pending);
	assign full = (fill >= FILL_W'(QUEUE_DEPTH));

	pcc_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_PAIRS   (MAX_PAIRS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.sample        (sample),
		.snap_push     (snap_push),
		.snap          (snap_in),
		.lasts_pending (lasts_pending)
	);

	// Each entry is the final count, sums and overflow mark of one set.
	pcc_queue #(
		.W     (SNAP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (snap_push),
		.din    (snap_in),
		.pop    (snap_pop),
		.dout   (snap_out),
		.count  (q_count)
	);

	// The back forms the spreads, classifies the set and runs the rounding search.
	pcc_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.MAX_PAIRS   (MAX_PAIRS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (q_count != '0),
		.snap         (snap_out),
		.snap_pop     (snap_pop),
		.result       (result),
		.result_valid (result_valid),
		.result_pop   (pop)
	);

	assign empty = !result_valid;

	// The queue must never take a set while it is already full.
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		snap_push |-> (q_count < CNT_W'(QUEUE_DEPTH)))
		else $error("set queue overflow");

	// The back only pops a set that the queue holds.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		snap_pop |-> (q_count != '0))
		else $error("pop from empty set queue");

	// Any error status carries a zero coefficient.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status != STAT_OK)) |-> (result.coefficient == '0))
		else $error("nonzero coefficient with error status");

	// The coefficient never leaves the range of -1.0 to +1.0.
	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((result.coefficient <= FIELD_W'(Q_ONE))
			&& (result.coefficient >= -FIELD_W'(Q_ONE))))
		else $error("coefficient out of range");

endmodule

`default_nettype wire
